// ----- src/asf_pkg.sv -----
`timescale 1ns / 1ps
// Package for the angular shape fit sweep: state types, fixed constants,
// the result record and the CORDIC arctangent table. No dependencies.
package asf_pkg;

  localparam logic [15:0] DEG180_Q88 = 16'd46080;
  localparam logic [15:0] DEG90_Q88  = 16'd23040;
  localparam logic [14:0] ERR_FULL   = 15'd25600;
  localparam logic [22:0] Z_MAX      = 23'd5898240;

  localparam logic [1:0] MODE_CONE  = 2'd0;
  localparam logic [1:0] MODE_DCONE = 2'd1;
  localparam logic [1:0] MODE_BAND  = 2'd2;

  localparam logic [1:0] REG_AXIS_X   = 2'd0;
  localparam logic [1:0] REG_AXIS_Y   = 2'd1;
  localparam logic [1:0] REG_AXIS_Z   = 2'd2;
  localparam logic [1:0] REG_FIT_MODE = 2'd3;

  typedef enum logic [2:0] {
    A_IDLE, A_DOT, A_SQ, A_SQRT, A_CORD, A_FIN
  } ang_state_t;

  typedef enum logic [3:0] {
    F_IDLE, F_SLD, F_SLDW, F_SCMP, F_SCMPW, F_SWRD, F_SWCMP,
    F_DIVSET, F_DIV, F_FIN, F_DONE
  } fit_state_t;

  typedef enum logic [2:0] {
    T_IDLE, T_LAUNCH, T_ANGLE, T_STORE, T_START, T_WAIT, T_HOLD
  } top_state_t;

  typedef struct packed {
    logic        valid;
    logic        reach;
    logic [15:0] key;
  } asf_store_t;

  typedef struct packed {
    logic [15:0] ang;
    logic [14:0] err;
    logic        ovf;
  } asf_result_t;

  function automatic logic [22:0] atan_entry(input logic [3:0] idx);
    logic [22:0] v;
    unique case (idx)
      4'd0:  v = 23'd2949120;
      4'd1:  v = 23'd1740967;
      4'd2:  v = 23'd919879;
      4'd3:  v = 23'd466945;
      4'd4:  v = 23'd234379;
      4'd5:  v = 23'd117304;
      4'd6:  v = 23'd58666;
      4'd7:  v = 23'd29335;
      4'd8:  v = 23'd14668;
      4'd9:  v = 23'd7334;
      4'd10: v = 23'd3667;
      4'd11: v = 23'd1833;
      4'd12: v = 23'd917;
      4'd13: v = 23'd458;
      4'd14: v = 23'd229;
      default: v = 23'd115;
    endcase
    return v;
  endfunction

endpackage

// ----- src/asf_keymem.sv -----
`timescale 1ns / 1ps
// Key memory: one write port and one registered read port.
// Uses no package.
module asf_keymem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/asf_angle.sv -----
`timescale 1ns / 1ps
// Angle unit: dot product, bitwise square root and 16 step CORDIC run in
// sequence on one datapath, then the key is folded by mode. Uses asf_pkg.
module asf_angle import asf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] ax,
  input  logic signed [15:0] ay,
  input  logic signed [15:0] az,
  input  logic signed [15:0] dx,
  input  logic signed [15:0] dy,
  input  logic signed [15:0] dz,
  input  logic [1:0]         mode,
  output logic               done,
  output logic [15:0]        key
);

  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  ang_state_t st_r, st_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic signed [33:0] acc_r, acc_nxt;
  logic [30:0] m_r, m_nxt;
  logic neg_r, neg_nxt;
  logic [60:0] n_r, n_nxt, r_r, r_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [24:0] z_r, z_nxt;

  logic signed [15:0] mul_a, mul_b;
  logic signed [31:0] prod;
  logic signed [33:0] acc_sum, dclamp, dmag;
  logic [61:0] msq;
  logic [60:0] bitv, tsum, r_step;
  logic [60:0] n_step;
  logic signed [33:0] sx, sy;
  logic signed [24:0] tab;
  logic [22:0] zc;
  logic [23:0] zsum;
  logic [15:0] abase, other;

  always_comb begin
    unique case (cnt_r[1:0])
      2'd0: begin
        mul_a = ax;
        mul_b = dx;
      end
      2'd1: begin
        mul_a = ay;
        mul_b = dy;
      end
      default: begin
        mul_a = az;
        mul_b = dz;
      end
    endcase
    prod = mul_a * mul_b;
    acc_sum = acc_r + 34'(prod);
    if (acc_sum > ONE_Q30) begin
      dclamp = ONE_Q30;
    end else if (acc_sum < -ONE_Q30) begin
      dclamp = -ONE_Q30;
    end else begin
      dclamp = acc_sum;
    end
    dmag = (dclamp < 0) ? -dclamp : dclamp;
    msq = 62'(m_r) * 62'(m_r);
    bitv = 61'(1) << {cnt_r, 1'b0};
    tsum = r_r + bitv;
    if (n_r >= tsum) begin
      n_step = n_r - tsum;
      r_step = (r_r >> 1) + bitv;
    end else begin
      n_step = n_r;
      r_step = r_r >> 1;
    end
    sx = x_r >>> cnt_r[3:0];
    sy = y_r >>> cnt_r[3:0];
    tab = $signed({2'b00, atan_entry(cnt_r[3:0])});
    if (z_r < 0) begin
      zc = '0;
    end else if (z_r > $signed({2'b00, Z_MAX})) begin
      zc = Z_MAX;
    end else begin
      zc = z_r[22:0];
    end
    zsum = {1'b0, zc} + 24'd128;
    abase = neg_r ? (DEG180_Q88 - zsum[23:8]) : zsum[23:8];
    other = DEG180_Q88 - abase;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      A_IDLE: if (start) st_nxt = A_DOT;
      A_DOT:  if (cnt_r == 5'd2) st_nxt = A_SQ;
      A_SQ:   st_nxt = A_SQRT;
      A_SQRT: if (cnt_r == 5'd0) st_nxt = A_CORD;
      A_CORD: if (cnt_r == 5'd15) st_nxt = A_FIN;
      A_FIN:  st_nxt = A_IDLE;
      default: st_nxt = A_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    m_nxt = m_r;
    neg_nxt = neg_r;
    n_nxt = n_r;
    r_nxt = r_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    done = 1'b0;
    key = abase;
    unique case (st_r)
      A_IDLE: begin
        cnt_nxt = '0;
        acc_nxt = '0;
      end
      A_DOT: begin
        acc_nxt = acc_sum;
        cnt_nxt = cnt_r + 5'd1;
        m_nxt = dmag[30:0];
        neg_nxt = dclamp < 0;
      end
      A_SQ: begin
        n_nxt = 61'(62'h1000_0000_0000_0000 - msq);
        r_nxt = '0;
        cnt_nxt = 5'd30;
      end
      A_SQRT: begin
        n_nxt = n_step;
        r_nxt = r_step;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          x_nxt = $signed({3'b000, m_r});
          y_nxt = $signed({3'b000, r_step[30:0]});
          z_nxt = '0;
          cnt_nxt = '0;
        end
      end
      A_CORD: begin
        if (y_r > 0) begin
          x_nxt = x_r + sy;
          y_nxt = y_r - sx;
          z_nxt = z_r + tab;
        end else begin
          x_nxt = x_r - sy;
          y_nxt = y_r + sx;
          z_nxt = z_r - tab;
        end
        cnt_nxt = cnt_r + 5'd1;
      end
      A_FIN: begin
        done = 1'b1;
        unique case (mode)
          MODE_DCONE: key = (other < abase) ? other : abase;
          MODE_BAND:  key = (abase > DEG90_Q88) ? (abase - DEG90_Q88) :
                                                  (DEG90_Q88 - abase);
          default:    key = abase;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    m_r <= m_nxt;
    neg_r <= neg_nxt;
    n_r <= n_nxt;
    r_r <= r_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

endmodule

// ----- src/asf_fit.sv -----
`timescale 1ns / 1ps
// Fit engine: stores keys per class, insertion sorts both memories, runs
// the merge sweep and a restoring divider. Uses asf_pkg and asf_keymem.
module asf_fit import asf_pkg::*; #(
  parameter int MAX_DIRECTIONS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  asf_store_t  store,
  input  logic        start,
  input  logic [1:0]  mode,
  output logic        done,
  output asf_result_t result
);

  localparam int AW = $clog2(MAX_DIRECTIONS);
  localparam int CW = $clog2(MAX_DIRECTIONS + 1);
  localparam int NW = CW + 15;
  localparam int BW = $clog2(NW);

  fit_state_t st_r, st_nxt;
  logic [CW-1:0] rc_r, rc_nxt, uc_r, uc_nxt;
  logic drop_r, drop_nxt;
  logic sel_r, sel_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [15:0] v_r, v_nxt, prev_r, prev_nxt, ang_r, ang_nxt;
  logic [CW-1:0] mis_r, mis_nxt, cov_r, cov_nxt, best_r, best_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] num_r, num_nxt, q_r, q_nxt;
  logic [BW-1:0] bitc_r, bitc_nxt;
  logic [14:0] err_r, err_nxt;
  logic ovf_r, ovf_nxt;

  logic r_we, u_we;
  logic [AW-1:0] r_wa, u_wa, r_ra, u_ra, sort_ra, sort_wa;
  logic [15:0] r_wd, u_wd, sort_wd, r_rd, u_rd;
  logic sort_we;

  logic [CW-1:0] n_sel, jm1;
  logic [15:0] rd_sel;
  logic sort_more, gt, sw_go, lt, forced, ge;
  logic [CW:0] nval, remsh;

  asf_keymem #(.DEPTH(MAX_DIRECTIONS), .AW(AW)) u_reach_mem (
    .clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd)
  );

  asf_keymem #(.DEPTH(MAX_DIRECTIONS), .AW(AW)) u_unreach_mem (
    .clk(clk), .we(u_we), .waddr(u_wa), .wdata(u_wd), .raddr(u_ra), .rdata(u_rd)
  );

  always_comb begin
    n_sel = sel_r ? uc_r : rc_r;
    rd_sel = sel_r ? u_rd : r_rd;
    sort_more = i_r < n_sel;
    gt = rd_sel > v_r;
    sw_go = (i_r < rc_r) && (j_r < uc_r);
    lt = r_rd < u_rd;
    jm1 = j_r - CW'(1);
    nval = lt ? ({1'b0, mis_r} - (CW+1)'(1) + {1'b0, cov_r}) :
                ({1'b0, mis_r} + {1'b0, cov_r} + (CW+1)'(1));
    forced = (rc_r == '0) || (uc_r == '0) ||
             ((mode == MODE_DCONE) && ((uc_r - cov_r) < CW'(3))) ||
             ((mode == MODE_BAND) && ((rc_r - mis_r) < CW'(3)));
    remsh = {rem_r, num_r[bitc_r]};
    ge = remsh >= {1'b0, rc_r};
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      F_IDLE:   if (start) st_nxt = F_SLD;
      F_SLD: begin
        if (sort_more) begin
          st_nxt = F_SLDW;
        end else if (sel_r) begin
          st_nxt = F_SWRD;
        end
      end
      F_SLDW:   st_nxt = F_SCMP;
      F_SCMP:   st_nxt = (j_r == '0) ? F_SLD : F_SCMPW;
      F_SCMPW:  st_nxt = gt ? F_SCMP : F_SLD;
      F_SWRD:   st_nxt = sw_go ? F_SWCMP : F_DIVSET;
      F_SWCMP:  st_nxt = F_SWRD;
      F_DIVSET: st_nxt = forced ? F_DONE : F_DIV;
      F_DIV:    if (bitc_r == '0) st_nxt = F_FIN;
      F_FIN:    st_nxt = F_DONE;
      F_DONE:   st_nxt = F_IDLE;
      default:  st_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    rc_nxt = rc_r;
    uc_nxt = uc_r;
    drop_nxt = drop_r;
    sel_nxt = sel_r;
    i_nxt = i_r;
    j_nxt = j_r;
    v_nxt = v_r;
    prev_nxt = prev_r;
    ang_nxt = ang_r;
    mis_nxt = mis_r;
    cov_nxt = cov_r;
    best_nxt = best_r;
    rem_nxt = rem_r;
    num_nxt = num_r;
    q_nxt = q_r;
    bitc_nxt = bitc_r;
    err_nxt = err_r;
    ovf_nxt = ovf_r;
    sort_we = 1'b0;
    sort_wa = i_r[AW-1:0];
    sort_wd = v_r;
    sort_ra = i_r[AW-1:0];
    done = 1'b0;
    unique case (st_r)
      F_IDLE: begin
        if (store.valid) begin
          if (store.reach) begin
            if (rc_r < CW'(MAX_DIRECTIONS)) rc_nxt = rc_r + CW'(1);
            else drop_nxt = 1'b1;
          end else begin
            if (uc_r < CW'(MAX_DIRECTIONS)) uc_nxt = uc_r + CW'(1);
            else drop_nxt = 1'b1;
          end
        end
        if (start) begin
          sel_nxt = 1'b0;
          i_nxt = CW'(1);
        end
      end
      F_SLD: begin
        if (!sort_more && !sel_r) begin
          sel_nxt = 1'b1;
          i_nxt = CW'(1);
        end else if (!sort_more) begin
          i_nxt = '0;
          j_nxt = '0;
          mis_nxt = rc_r;
          cov_nxt = '0;
          best_nxt = rc_r;
          prev_nxt = '0;
          ang_nxt = '0;
        end
      end
      F_SLDW: begin
        v_nxt = rd_sel;
        j_nxt = i_r;
      end
      F_SCMP: begin
        sort_ra = jm1[AW-1:0];
        if (j_r == '0) begin
          sort_we = 1'b1;
          sort_wa = '0;
          sort_wd = v_r;
          i_nxt = i_r + CW'(1);
        end
      end
      F_SCMPW: begin
        sort_we = 1'b1;
        sort_wa = j_r[AW-1:0];
        if (gt) begin
          sort_wd = rd_sel;
          j_nxt = jm1;
        end else begin
          sort_wd = v_r;
          i_nxt = i_r + CW'(1);
        end
      end
      F_SWCMP: begin
        if (lt) begin
          i_nxt = i_r + CW'(1);
          mis_nxt = mis_r - CW'(1);
          prev_nxt = r_rd;
        end else begin
          j_nxt = j_r + CW'(1);
          cov_nxt = cov_r + CW'(1);
        end
        if (nval <= {1'b0, best_r}) begin
          best_nxt = nval[CW-1:0];
          ang_nxt = lt ? r_rd : prev_r;
        end
      end
      F_DIVSET: begin
        num_nxt = NW'(best_r) * NW'(ERR_FULL) + NW'(rc_r >> 1);
        rem_nxt = '0;
        q_nxt = '0;
        bitc_nxt = BW'(NW - 1);
        if (forced) begin
          err_nxt = ERR_FULL;
          ovf_nxt = drop_r;
          rc_nxt = '0;
          uc_nxt = '0;
          drop_nxt = 1'b0;
        end
      end
      F_DIV: begin
        rem_nxt = ge ? CW'(remsh - {1'b0, rc_r}) : CW'(remsh);
        q_nxt = {q_r[NW-2:0], ge};
        bitc_nxt = bitc_r - BW'(1);
      end
      F_FIN: begin
        err_nxt = (q_r > NW'(ERR_FULL)) ? ERR_FULL : q_r[14:0];
        ovf_nxt = drop_r;
        rc_nxt = '0;
        uc_nxt = '0;
        drop_nxt = 1'b0;
      end
      F_DONE: done = 1'b1;
      default: begin
      end
    endcase
  end

  always_comb begin
    r_we = 1'b0;
    u_we = 1'b0;
    r_wa = sort_wa;
    u_wa = sort_wa;
    r_wd = sort_wd;
    u_wd = sort_wd;
    if (st_r == F_IDLE) begin
      r_wa = rc_r[AW-1:0];
      u_wa = uc_r[AW-1:0];
      r_wd = store.key;
      u_wd = store.key;
      r_we = store.valid && store.reach && (rc_r < CW'(MAX_DIRECTIONS));
      u_we = store.valid && !store.reach && (uc_r < CW'(MAX_DIRECTIONS));
    end else begin
      r_we = sort_we && !sel_r;
      u_we = sort_we && sel_r;
    end
    r_ra = (st_r == F_SWRD) ? i_r[AW-1:0] : sort_ra;
    u_ra = (st_r == F_SWRD) ? j_r[AW-1:0] : sort_ra;
  end

  assign result.ang = ang_r;
  assign result.err = err_r;
  assign result.ovf = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
      rc_r <= '0;
      uc_r <= '0;
      drop_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rc_r <= rc_nxt;
      uc_r <= uc_nxt;
      drop_r <= drop_nxt;
    end
    sel_r <= sel_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    v_r <= v_nxt;
    prev_r <= prev_nxt;
    ang_r <= ang_nxt;
    mis_r <= mis_nxt;
    cov_r <= cov_nxt;
    best_r <= best_nxt;
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    q_r <= q_nxt;
    bitc_r <= bitc_nxt;
    err_r <= err_nxt;
    ovf_r <= ovf_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (rc_r <= CW'(MAX_DIRECTIONS)) && (uc_r <= CW'(MAX_DIRECTIONS)))
    else $error("key count beyond capacity");

  a_sweep_index: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == F_SWCMP) |-> ((i_r < rc_r) && (j_r < uc_r)))
    else $error("sweep compare past the end of a class");

  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == F_SWRD) |-> ((best_r <= rc_r) && (cov_r <= uc_r)))
    else $error("sweep bookkeeping out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == F_DIV) |-> (rem_r < rc_r))
    else $error("divider remainder not below divisor");

endmodule

// ----- src/angular_shape_fit_sweep.sv -----
`timescale 1ns / 1ps
// Top level of the angular shape fit sweep: handshakes, configuration
// registers, output register. Uses asf_pkg, asf_angle and asf_fit.
//
//  Channel   Direction  Word contents
//  in_*      input      tdata dir_x, dir_y, dir_z; tuser reachable; tlast last_item
//  out_*     output     tdata half_angle, fit_error; tuser overflow
//  cfg_*     input      register index 0..3, 16 bit write data
//
// After each accepted input word, in_tready stays low while the angle unit
// runs its 31 step square root and 16 step CORDIC and the key is stored.
// A word with tlast adds the two insertion sorts and the merge sweep, then
// the restoring divider unless the error is forced to full scale.
// Reset is synchronous; no clearing pass is needed. A result waiting on
// out_tready does not block new input words until the next result is ready.
module angular_shape_fit_sweep import asf_pkg::*; #(
  parameter int MAX_DIRECTIONS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // dir_x, dir_y, dir_z
  input  logic [0:0]  in_tuser,   // reachable
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // half_angle, fit_error, zero pad
  output logic [0:0]  out_tuser,  // overflow
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  top_state_t st_r, st_nxt;
  logic signed [15:0] ax_r, ay_r, az_r;
  logic [1:0] fm_r;
  logic signed [15:0] dx_r, dy_r, dz_r;
  logic reach_r, last_r;
  logic [1:0] mode_r;
  logic [15:0] key_r;
  logic out_valid_r;
  logic [31:0] out_data_r;
  logic out_ovf_r;

  logic accept, ang_start, ang_done, fit_start, fit_done, load;
  logic [15:0] ang_key;
  asf_store_t store;
  asf_result_t fit_res;

  assign accept = in_tvalid && in_tready;

  asf_angle u_angle (
    .clk(clk), .rst_n(rst_n), .start(ang_start),
    .ax(ax_r), .ay(ay_r), .az(az_r),
    .dx(dx_r), .dy(dy_r), .dz(dz_r),
    .mode(mode_r), .done(ang_done), .key(ang_key)
  );

  asf_fit #(.MAX_DIRECTIONS(MAX_DIRECTIONS)) u_fit (
    .clk(clk), .rst_n(rst_n), .store(store), .start(fit_start),
    .mode(mode_r), .done(fit_done), .result(fit_res)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      T_IDLE:   if (accept) st_nxt = T_LAUNCH;
      T_LAUNCH: st_nxt = T_ANGLE;
      T_ANGLE:  if (ang_done) st_nxt = T_STORE;
      T_STORE:  st_nxt = last_r ? T_START : T_IDLE;
      T_START:  st_nxt = T_WAIT;
      T_WAIT:   if (fit_done) st_nxt = T_HOLD;
      T_HOLD:   if (!out_valid_r) st_nxt = T_IDLE;
      default:  st_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    in_tready = st_r == T_IDLE;
    ang_start = st_r == T_LAUNCH;
    fit_start = st_r == T_START;
    load = (st_r == T_HOLD) && !out_valid_r;
    store.valid = st_r == T_STORE;
    store.reach = reach_r;
    store.key = key_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= T_IDLE;
      ax_r <= '0;
      ay_r <= '0;
      az_r <= 16'sd32767;
      fm_r <= MODE_CONE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_AXIS_X:   ax_r <= cfg_wdata;
          REG_AXIS_Y:   ay_r <= cfg_wdata;
          REG_AXIS_Z:   az_r <= cfg_wdata;
          REG_FIT_MODE: fm_r <= cfg_wdata[1:0];
          default:      fm_r <= fm_r;
        endcase
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      dx_r <= in_tdata[15:0];
      dy_r <= in_tdata[31:16];
      dz_r <= in_tdata[47:32];
      reach_r <= in_tuser[0];
      last_r <= in_tlast;
      mode_r <= fm_r;
    end
    if (ang_done) begin
      key_r <= ang_key;
    end
    if (load) begin
      out_data_r <= {1'b0, fit_res.err, fit_res.ang};
      out_ovf_r <= fit_res.ovf;
    end
  end

endmodule
